### design/bfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants and helpers for the block frequency statistic.
// ----------------------------------------------------------------------------
package bfs_pkg;

	// configuration register indexes
	localparam int REG_BLOCK_LENGTH = 0;
	localparam int REG_BLOCK_TOTAL  = 1;
	localparam int CFG_INDEX_W      = 2;

	// register reset values
	localparam int DEF_BLOCK_LENGTH = 128;
	localparam int DEF_BLOCK_TOTAL  = 1;

	// shortest block in bits, also the byte size
	localparam int MIN_BLOCK_LENGTH = 8;

	// result field widths
	localparam int ONES_W   = 16;
	localparam int TERM_W   = 32;
	localparam int SUM_W    = 56;
	localparam int NUMBER_W = 24;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage

### design/bfs_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_count
// Input register and bit counting: splits each byte at the block boundary,
// keeps the per-block ones count and the block index.
// ----------------------------------------------------------------------------
module bfs_count #(
	parameter int LENGTH_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    take,
	input  logic [7:0]              data_byte,
	input  logic                    seq_clear,
	input  logic [LENGTH_WIDTH-1:0] len,
	input  logic [COUNT_WIDTH-1:0]  total,
	output logic                    valid_s2,
	output logic [LENGTH_WIDTH-1:0] ones_s2,
	output logic [LENGTH_WIDTH-1:0] diff_s2,
	output logic [COUNT_WIDTH-1:0]  number_s2,
	output logic                    last_s2
);
	import bfs_pkg::*;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic [LENGTH_WIDTH-1:0] ones_q;
	logic [LENGTH_WIDTH-1:0] bits_q;
	logic [COUNT_WIDTH-1:0]  blocks_q;
	logic                    finished_q;

	logic [LENGTH_WIDTH-1:0] rem;
	logic                    done;
	logic [8:0]              head_mask;
	logic [7:0]              head_bits;
	logic [7:0]              tail_bits;
	logic [LENGTH_WIDTH-1:0] ones_blk;
	logic [LENGTH_WIDTH:0]   twice;
	logic [LENGTH_WIDTH:0]   len_x;
	logic [LENGTH_WIDTH:0]   diff_x;
	logic [COUNT_WIDTH:0]    blocks_inc;
	logic                    last;
	logic                    live;

	// bits still missing from the current block, at least one
	assign rem       = len - bits_q;
	assign done      = rem <= LENGTH_WIDTH'(MIN_BLOCK_LENGTH);
	assign head_mask = (9'd1 << rem[3:0]) - 9'd1;
	assign head_bits = byte_s1 & head_mask[7:0];
	assign tail_bits = byte_s1 & ~head_mask[7:0];
	assign ones_blk  = ones_q + LENGTH_WIDTH'(popcount8(head_bits));
	assign twice     = {ones_blk, 1'b0};
	assign len_x     = {1'b0, len};
	assign diff_x    = (twice >= len_x) ? (twice - len_x) : (len_x - twice);
	assign blocks_inc = {1'b0, blocks_q} + (COUNT_WIDTH+1)'(1);
	assign last      = blocks_inc >= {1'b0, total};
	assign live      = en && valid_s1 && !finished_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q     <= '0;
			bits_q     <= '0;
			blocks_q   <= '0;
			finished_q <= 1'b0;
		end else if (seq_clear) begin
			ones_q     <= '0;
			bits_q     <= '0;
			blocks_q   <= '0;
			finished_q <= 1'b0;
		end else if (live) begin
			if (done && last) begin
				// rest of the byte is dropped, sequence closes
				ones_q     <= '0;
				bits_q     <= '0;
				blocks_q   <= '0;
				finished_q <= 1'b1;
			end else if (done) begin
				ones_q   <= LENGTH_WIDTH'(popcount8(tail_bits));
				bits_q   <= LENGTH_WIDTH'(4'd8 - rem[3:0]);
				blocks_q <= blocks_inc[COUNT_WIDTH-1:0];
			end else begin
				ones_q <= ones_q + LENGTH_WIDTH'(popcount8(byte_s1));
				bits_q <= bits_q + LENGTH_WIDTH'(MIN_BLOCK_LENGTH);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && !finished_q && done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ones_s2   <= ones_blk;
			diff_s2   <= diff_x[LENGTH_WIDTH-1:0];
			number_s2 <= blocks_q;
			last_s2   <= last;
		end
	end

endmodule

### design/bfs_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_accum
// Squares the block deviation, adds it into the saturating sum and holds
// the result register.
// ----------------------------------------------------------------------------
module bfs_accum #(
	parameter int LENGTH_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          seq_clear,
	input  logic                          valid_s2,
	input  logic [LENGTH_WIDTH-1:0]       ones_s2,
	input  logic [LENGTH_WIDTH-1:0]       diff_s2,
	input  logic [COUNT_WIDTH-1:0]        number_s2,
	input  logic                          last_s2,
	output logic                          out_valid,
	output logic [bfs_pkg::ONES_W-1:0]    block_ones,
	output logic [bfs_pkg::TERM_W-1:0]    block_term,
	output logic [bfs_pkg::SUM_W-1:0]     running_sum,
	output logic [bfs_pkg::NUMBER_W-1:0]  block_number,
	output logic                          last_block
);
	import bfs_pkg::*;

	localparam int PW = 2 * LENGTH_WIDTH;

	logic                    valid_s3;
	logic [PW-1:0]           prod_s3;
	logic [LENGTH_WIDTH-1:0] ones_s3;
	logic [COUNT_WIDTH-1:0]  number_s3;
	logic                    last_s3;
	logic [SUM_W-1:0]        acc_q;

	logic [63:0]             prod_ext;
	logic [TERM_W-1:0]       term_sat;
	logic [SUM_W:0]          sum_x;
	logic [SUM_W-1:0]        sum_sat;

	assign prod_ext = 64'(prod_s3);
	assign term_sat = (prod_ext > 64'(32'hFFFF_FFFF)) ? '1 : prod_ext[TERM_W-1:0];
	// full product goes into the sum, which saturates at its own width; the reported term saturates separately
	assign sum_x    = {1'b0, acc_q} + (SUM_W+1)'(prod_s3);
	assign sum_sat  = sum_x[SUM_W] ? '1 : sum_x[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3   <= PW'(diff_s2) * PW'(diff_s2);
			ones_s3   <= ones_s2;
			number_s3 <= number_s2;
			last_s3   <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s3) begin
			block_ones   <= ONES_W'(ones_s3);
			block_term   <= term_sat;
			running_sum  <= sum_sat;
			block_number <= NUMBER_W'(number_s3);
			last_block   <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (seq_clear) begin
			acc_q <= '0;
		end else if (en && valid_s3) begin
			acc_q <= last_s3 ? '0 : sum_sat;
		end
	end

endmodule

### design/block_frequency_statistic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_frequency_statistic
// Block frequency statistic over a byte stream, bit zero of each byte first.
// ----------------------------------------------------------------------------
// usage
//   input channel: data_byte with in_valid / in_ready, one byte per transfer
//   output channel: one result per completed block with out_valid / out_ready
//   config: cfg_we writes cfg_data to register cfg_index (0 block_length,
//     1 block_total); any write to either register starts a new sequence
//   throughput: one byte per clock unless stalled; a block of at least
//     eight bits ends in at most one byte, so each byte gives at most one
//     result; the byte that completes a block passes the input register,
//     count stage, squaring stage and result register before its result
//     is presented
//   stall: all stages advance together; while a result waits in the result
//     register and out_ready is low, in_ready is low
//   end of sequence: after the last block the rest of that byte and every
//     later byte are taken without a result until the next write or reset
//   reset: registers go to block_length 128, block_total 1, sums cleared
// ----------------------------------------------------------------------------
module block_frequency_statistic #(
	parameter int LENGTH_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [bfs_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [((LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH)-1:0] cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [7:0]                              data_byte,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [bfs_pkg::ONES_W-1:0]              block_ones,
	output logic [bfs_pkg::TERM_W-1:0]              block_term,
	output logic [bfs_pkg::SUM_W-1:0]               running_sum,
	output logic [bfs_pkg::NUMBER_W-1:0]            block_number,
	output logic                                    last_block
);
	import bfs_pkg::*;

	logic [LENGTH_WIDTH-1:0] block_length_q;
	logic [COUNT_WIDTH-1:0]  block_total_q;
	logic [LENGTH_WIDTH-1:0] len;
	logic [COUNT_WIDTH-1:0]  total;
	logic                    wr_length;
	logic                    wr_total;
	logic                    seq_clear;
	logic                    en;
	logic                    take;

	logic                    valid_s2;
	logic [LENGTH_WIDTH-1:0] ones_s2;
	logic [LENGTH_WIDTH-1:0] diff_s2;
	logic [COUNT_WIDTH-1:0]  number_s2;
	logic                    last_s2;

	assign wr_length = cfg_we && (cfg_index == CFG_INDEX_W'(REG_BLOCK_LENGTH));
	assign wr_total  = cfg_we && (cfg_index == CFG_INDEX_W'(REG_BLOCK_TOTAL));
	assign seq_clear = wr_length || wr_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= LENGTH_WIDTH'(DEF_BLOCK_LENGTH);
			block_total_q  <= COUNT_WIDTH'(DEF_BLOCK_TOTAL);
		end else begin
			if (wr_length) begin
				block_length_q <= cfg_data[LENGTH_WIDTH-1:0];
			end
			if (wr_total) begin
				block_total_q <= cfg_data[COUNT_WIDTH-1:0];
			end
		end
	end

	// short lengths act as eight bits, a zero total as one block
	assign len   = (block_length_q < LENGTH_WIDTH'(MIN_BLOCK_LENGTH)) ?
		LENGTH_WIDTH'(MIN_BLOCK_LENGTH) : block_length_q;
	assign total = (block_total_q == '0) ? COUNT_WIDTH'(1) : block_total_q;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign take     = in_valid && en;

	bfs_count #(
		.LENGTH_WIDTH(LENGTH_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.take     (take),
		.data_byte(data_byte),
		.seq_clear(seq_clear),
		.len      (len),
		.total    (total),
		.valid_s2 (valid_s2),
		.ones_s2  (ones_s2),
		.diff_s2  (diff_s2),
		.number_s2(number_s2),
		.last_s2  (last_s2)
	);

	bfs_accum #(
		.LENGTH_WIDTH(LENGTH_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.seq_clear   (seq_clear),
		.valid_s2    (valid_s2),
		.ones_s2     (ones_s2),
		.diff_s2     (diff_s2),
		.number_s2   (number_s2),
		.last_s2     (last_s2),
		.out_valid   (out_valid),
		.block_ones  (block_ones),
		.block_term  (block_term),
		.running_sum (running_sum),
		.block_number(block_number),
		.last_block  (last_block)
	);

endmodule
